// ===== rtl/core/sfir_pkg.sv =====
// Shared constants, types and register codes of the symmetric line FIR filter.
package sfir_pkg;

  localparam int RADIUS    = 3;
  localparam int TAPS      = 2 * RADIUS + 1;
  localparam int MAX_LINE  = 4096;
  localparam int MIN_LINE  = RADIUS + 1;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int LEN_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int FRAC_W    = 14;

  // centre offset and clipped border distances, window slot, flush counter
  localparam int OFS_W     = $clog2(RADIUS + 1);
  localparam int SLOT_W    = $clog2(TAPS);
  localparam int FL_W      = $clog2(RADIUS + 1);

  // unsigned pair sum widened by a sign bit, times a signed coefficient
  localparam int OPND_W    = SAMPLE_W + 2;
  localparam int PROD_W    = OPND_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));

  localparam logic signed [COEF_W-1:0] COEF_CENTER_RST = COEF_W'(16384);
  localparam logic [LEN_W-1:0]         LINE_LENGTH_RST = LEN_W'(640);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_CENTER = 3'd0,
    REG_COEF_ONE    = 3'd1,
    REG_COEF_TWO    = 3'd2,
    REG_COEF_THREE  = 3'd3,
    REG_LINE_LENGTH = 3'd4
  } cfg_reg_t;

  // one output position queued for the product stage
  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] ctr;   // slot of the centre tap in the window
    logic [OFS_W-1:0] lft;   // distance to the line start, clipped
    logic [OFS_W-1:0] rgt;   // distance to the line end, clipped
    logic             eol;
  } job_t;

endpackage

// ===== rtl/core/sfir_if.sv =====
// Valid/ready channel interfaces: input samples, filtered results, register writes.
interface sfir_sample_if;
  import sfir_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sfir_result_if;
  import sfir_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered;
  logic                end_of_line;
  modport source (output valid, output filtered, output end_of_line, input ready);
  modport sink   (input valid, input filtered, input end_of_line, output ready);
endinterface

interface sfir_cfg_if;
  import sfir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/symmetric_fir_line_reflect_border_core.sv =====
// Symmetric 7-tap line FIR with reflected borders, rounding and saturation.
//
// Usage: samples of one line arrive on the samples channel, one item per
// clock when the result side keeps up. Each accepted sample from the fourth
// of a line on yields one filtered item on the results channel; the last
// sample of a line (line_length, clamped to 4..4096, latched at the line's
// first sample) yields four, the last one flagged end_of_line. While those
// three extra items are issued the samples channel is held not ready.
// A filtered item passes the job register, the product register and the result
// register after the sample that completes its window is accepted. The pipeline
// advances whenever the result register is empty or being taken, so a stalled
// receiver freezes every stage and the sample input with it; nothing is dropped.
// Registers are written on the cfg channel (always ready); the user must write
// them only while the block is idle, which the block itself does not enforce.
// Reset clears the window, the line position and the pipeline, and loads
// coef_center = 1.0 (Q2.14), other coefficients 0, line_length 640.
module symmetric_fir_line_reflect_border_core (
  input  logic          clk,
  input  logic          rst,
  sfir_sample_if.sink   samples,
  sfir_result_if.source results,
  sfir_cfg_if.sink      cfg
);
  import sfir_pkg::*;

  logic signed [COEF_W-1:0] coef [RADIUS+1];
  logic [LEN_W-1:0]         line_length;
  logic [SAMPLE_W-1:0]      win [TAPS];
  logic [LEN_W-1:0]         pos;
  logic [LEN_W-1:0]         act_len;
  logic [FL_W-1:0]          fl;
  job_t                     job;
  job_t                     job_next;

  logic                     m_valid;
  logic                     m_eol;
  logic signed [PROD_W-1:0] prod [RADIUS+1];
  logic signed [PROD_W-1:0] prod_next [RADIUS+1];

  logic                     res_valid;
  logic [SAMPLE_W-1:0]      filtered;
  logic                     end_of_line;

  logic                     adv;
  logic                     acc;
  logic [LEN_W-1:0]         eff_len;
  logic [LEN_W-1:0]         len_cur;
  logic                     is_last;
  logic [LEN_W-1:0]         fl_dist;
  logic [LEN_W-1:0]         pr_dist;
  logic [SLOT_W-1:0]        slot [TAPS];
  logic [SAMPLE_W-1:0]      tapv [TAPS];
  logic signed [ACC_W-1:0]  sum;
  logic [SAMPLE_W-1:0]      sat;

  // ---------------------------------------------------------------- control
  assign adv           = !res_valid || results.ready;
  assign samples.ready = adv && (fl == '0);
  assign acc           = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  always_comb begin
    if (line_length < LEN_W'(MIN_LINE))      eff_len = LEN_W'(MIN_LINE);
    else if (line_length > LEN_W'(MAX_LINE)) eff_len = LEN_W'(MAX_LINE);
    else                                     eff_len = line_length;
  end

  assign len_cur = (pos == '0) ? eff_len : act_len;
  assign is_last = (pos == len_cur - LEN_W'(1));

  always_comb begin
    job_next = '0;
    fl_dist  = act_len - LEN_W'(1) - LEN_W'(fl - FL_W'(1));
    pr_dist  = pos - LEN_W'(RADIUS);
    if (fl != '0) begin
      // flush: centre moves towards the newest sample, which is the line end
      job_next.valid = 1'b1;
      job_next.ctr   = OFS_W'(fl - FL_W'(1));
      job_next.rgt   = OFS_W'(fl - FL_W'(1));
      job_next.lft   = (fl_dist >= LEN_W'(RADIUS)) ? OFS_W'(RADIUS) : OFS_W'(fl_dist);
      job_next.eol   = (fl == FL_W'(1));
    end else if (acc && pos >= LEN_W'(RADIUS)) begin
      job_next.valid = 1'b1;
      job_next.ctr   = OFS_W'(RADIUS);
      job_next.rgt   = OFS_W'(RADIUS);
      job_next.lft   = (pr_dist >= LEN_W'(RADIUS)) ? OFS_W'(RADIUS) : OFS_W'(pr_dist);
      job_next.eol   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      act_len <= LINE_LENGTH_RST;
      fl      <= '0;
      job     <= '0;
      for (int i = 0; i < TAPS; i++) win[i] <= '0;
    end else begin
      if (acc) begin
        win[0] <= samples.sample;
        for (int i = 1; i < TAPS; i++) win[i] <= win[i-1];
        if (pos == '0) act_len <= eff_len;
        pos <= is_last ? '0 : pos + LEN_W'(1);
      end
      if (adv) begin
        job <= job_next;
        if (fl != '0)           fl <= fl - FL_W'(1);
        else if (acc && is_last) fl <= FL_W'(RADIUS);
      end
    end
  end

  // ------------------------------------------------------------ config port
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]     <= COEF_CENTER_RST;
      for (int d = 1; d <= RADIUS; d++) coef[d] <= '0;
      line_length <= LINE_LENGTH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_COEF_CENTER: coef[0]     <= cfg.data;
        REG_COEF_ONE:    coef[1]     <= cfg.data;
        REG_COEF_TWO:    coef[2]     <= cfg.data;
        REG_COEF_THREE:  coef[3]     <= cfg.data;
        REG_LINE_LENGTH: line_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- tap selection
  // Tap k of the kernel sits at line index o+k; window slot s holds index p-s.
  // Off the left end the index mirrors to -(o+k)-1, off the right end (only
  // during flush, where p is the last index) to 2L-1-(o+k).
  always_comb begin
    int k;
    int c;
    int l;
    int r;
    int s;
    c = int'(job.ctr);
    l = int'(job.lft);
    r = int'(job.rgt);
    for (int j = 0; j < TAPS; j++) begin
      k = j - RADIUS;
      if (l + k < 0)   s = c + 2 * l + k + 1;
      else if (k > r)  s = k - r - 1;
      else             s = c - k;
      slot[j] = SLOT_W'(s);
      tapv[j] = win[slot[j]];
    end
  end

  always_comb begin
    logic signed [OPND_W-1:0] opnd;
    opnd         = signed'({2'b00, tapv[RADIUS]});
    prod_next[0] = opnd * coef[0];
    for (int d = 1; d <= RADIUS; d++) begin
      opnd         = signed'(OPND_W'({1'b0, tapv[RADIUS-d]} + {1'b0, tapv[RADIUS+d]}));
      prod_next[d] = opnd * coef[d];
    end
  end

  // ------------------------------------------------- sum, round, saturate
  always_comb begin
    sum = ROUND_HALF;
    for (int d = 0; d <= RADIUS; d++) sum = sum + ACC_W'(prod[d]);
    if (sum[ACC_W-1])                        sat = '0;
    else if (|sum[ACC_W-2:FRAC_W+SAMPLE_W])  sat = '1;
    else                                     sat = sum[FRAC_W+SAMPLE_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= job.valid;
      res_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d <= RADIUS; d++) prod[d] <= prod_next[d];
      m_eol       <= job.eol;
      filtered    <= sat;
      end_of_line <= m_eol;
    end
  end

  assign results.valid       = res_valid;
  assign results.filtered    = filtered;
  assign results.end_of_line = end_of_line;

  // ------------------------------------------------------------ assertions
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (acc && is_last) |=> (fl == FL_W'(RADIUS)))
    else $error("flush not started after last sample of a line");

  a_pos_in_line: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) |-> (pos < act_len))
    else $error("line position beyond latched length");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (act_len >= LEN_W'(MIN_LINE)) && (act_len <= LEN_W'(MAX_LINE)))
    else $error("latched line length out of range");

  a_eol_flush_end: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.eol) |-> (job.ctr == '0) && (fl == '0))
    else $error("end of line marked away from the flush end");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the symmetric line FIR with reflected borders.
module tb;
  import sfir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register lives here
  localparam int IDLE_GAP    = 8;
  localparam int GAP_MAX     = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int LINE_ITEMS  = 280;
  localparam int PRESS_LEN   = 32;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                eol;
  } filt_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    bit                   typed;
    logic [SAMPLE_W-1:0]  want;
  } row_t;

  logic clk;
  logic rst;

  sfir_sample_if smp();
  sfir_result_if res();
  sfir_cfg_if    cfg();

  symmetric_fir_line_reflect_border_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .cfg     (cfg)
  );

  // filter state as seen by the predictor
  logic signed [COEF_W-1:0] coef_m [0:RADIUS];
  logic [LEN_W-1:0]         len_reg;
  logic [SAMPLE_W-1:0]      win [0:TAPS-1];
  int                       pos;
  int                       act_len;

  filt_t filt_pending[$];
  int    errors;
  bit    calm;
  bit    hold_req;

  // directed lines: typed values hold for every item the row releases
  row_t plan [36] = '{
    '{ROW_WRITE,  REG_LINE_LENGTH, 16'h0000, 1'b0, 16'h0000},  // clamps to shortest line
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b1, 16'hFFFF},  // unity kernel after reset
    '{ROW_WRITE,  REG_COEF_CENTER, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b1, 16'h0000},  // negative sum floors at 0
    '{ROW_WRITE,  REG_COEF_CENTER, 16'h2000, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_NONE,        16'hFFFF, 1'b0, 16'h0000},  // must be ignored
    '{ROW_SAMPLE, REG_NONE,        16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h0001, 1'b1, 16'h0001},  // exact half rounds up
    '{ROW_WRITE,  REG_COEF_ONE,    16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_TWO,    16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_THREE,  16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_CENTER, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'hFFFF, 1'b1, 16'hFFFF},  // saturates high
    '{ROW_WRITE,  REG_COEF_CENTER, 16'h4000, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_ONE,    16'hE000, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_TWO,    16'h1000, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_COEF_THREE,  16'h8000, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_LINE_LENGTH, 16'h0006, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h5555, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_LINE_LENGTH, 16'h0009, 1'b0, 16'h0000},  // mid-line: next line only
    '{ROW_SAMPLE, REG_NONE,        16'hAAAA, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_NONE,        16'h7FFF, 1'b0, 16'h0000}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_len(logic [LEN_W-1:0] l);
    if (l < MIN_LINE) return MIN_LINE;
    if (l > MAX_LINE) return MAX_LINE;
    return int'(l);
  endfunction

  // sample at line index idx, mirrored into the line, seen from newest index p
  function automatic longint tap(int p, int len, int idx);
    int m;
    m = idx;
    if (m < 0) m = -m - 1;
    else if (m >= len) m = 2 * len - 1 - m;
    if (m < 0 || m > p || p - m >= TAPS) return 0;
    return longint'(win[p - m]);
  endfunction

  function automatic logic [SAMPLE_W-1:0] filt_at(int p, int len, int o);
    longint acc;
    acc = longint'(coef_m[0]) * tap(p, len, o);
    for (int d = 1; d <= RADIUS; d++)
      acc += longint'(coef_m[d]) * (tap(p, len, o - d) + tap(p, len, o + d));
    acc += longint'(ROUND_HALF);
    if (acc < 0) return '0;
    acc = acc >>> FRAC_W;
    if (acc > 65535) return '1;
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_coef(bit centre);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 65535));
      default: begin
        if (centre) return 16'($urandom_range(2048, 16384));
        return 16'(int'($urandom_range(0, 8192)) - 4096);
      end
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic fir_accept(input logic [SAMPLE_W-1:0] s, input bit typed,
                            input logic [SAMPLE_W-1:0] want);
    int    first;
    filt_t r;
    if (pos == 0) act_len = clamp_len(len_reg);
    for (int k = TAPS - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = s;
    first = filt_pending.size();
    if (pos >= RADIUS) begin
      r.value = filt_at(pos, act_len, pos - RADIUS);
      r.eol   = (pos - RADIUS + 1 == act_len);
      filt_pending = {filt_pending, r};
    end
    if (pos + 1 >= act_len) begin
      // line end: flush the positions whose right taps are mirrored
      for (int o = pos - RADIUS + 1; o <= pos; o++) begin
        r.value = filt_at(pos, act_len, o);
        r.eol   = (o == pos);
        filt_pending = {filt_pending, r};
      end
      pos = 0;
    end else begin
      pos++;
    end
    if (typed)
      for (int k = first; k < filt_pending.size(); k++) filt_pending[k].value = want;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input logic [SAMPLE_W-1:0] want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    fir_accept(s, typed, want);
    @(negedge clk);
  endtask

  // registers change only with the pipeline drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    smp.valid <= 1'b0;
    while (filt_pending.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_COEF_CENTER, REG_COEF_ONE, REG_COEF_TWO, REG_COEF_THREE: coef_m[idx[1:0]] = val;
      REG_LINE_LENGTH: len_reg = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int    gap;
    bit    hold_done;
    filt_t want;
    hold_done = 1'b0;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_req && !hold_done) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap != 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      if (filt_pending.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected item: filtered %0d eol %0b", res.filtered, res.end_of_line);
      end else begin
        want = filt_pending.pop_front();
        if (res.filtered !== want.value || res.end_of_line !== want.eol) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("mismatch: filtered %0d eol %0b, expected %0d eol %0b",
                     res.filtered, res.end_of_line, want.value, want.eol);
        end
      end
      @(negedge clk);
    end
  end

  initial begin : line_source
    int sent;
    int n;
    int l;
    rst        = 1'b1;
    smp.valid  = 1'b0;
    smp.sample = '0;
    cfg.valid  = 1'b0;
    cfg.index  = REG_COEF_CENTER;
    cfg.data   = '0;
    errors     = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    coef_m[0]  = COEF_CENTER_RST;
    for (int d = 1; d <= RADIUS; d++) coef_m[d] = '0;
    len_reg    = LINE_LENGTH_RST;
    for (int k = 0; k < TAPS; k++) win[k] = '0;
    pos        = 0;
    act_len    = clamp_len(LINE_LENGTH_RST);
    sent       = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].data, plan[i].typed, plan[i].want);
        sent++;
      end
    end

    // random kernels and short lines, sometimes stopping mid-line
    while (sent < LINE_ITEMS - PRESS_LEN) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1)) write_reg(REG_COEF_CENTER, pick_coef(1'b1));
        if ($urandom_range(0, 1)) write_reg(REG_COEF_ONE, pick_coef(1'b0));
        if ($urandom_range(0, 1)) write_reg(REG_COEF_TWO, pick_coef(1'b0));
        if ($urandom_range(0, 1)) write_reg(REG_COEF_THREE, pick_coef(1'b0));
      end
      if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: l = $urandom_range(0, MIN_LINE - 1);
          1: l = $urandom_range(17, 64);
          default: l = $urandom_range(MIN_LINE, 16);
        endcase
        write_reg(REG_LINE_LENGTH, 16'(l));
      end
      n = (pos != 0) ? act_len - pos : 0;
      n += $urandom_range(1, 3) * clamp_len(len_reg);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, clamp_len(len_reg) - 1);
      if (n > LINE_ITEMS - PRESS_LEN - sent) n = LINE_ITEMS - PRESS_LEN - sent;
      repeat (n) send_sample(pick_sample(), 1'b0, '0);
      sent += n;
    end

    // start of a full-size line; the receiver holds off meanwhile so the input backs up
    calm = 1'b1;
    write_reg(REG_LINE_LENGTH, '1);
    n = ((pos != 0) ? act_len - pos : 0) + PRESS_LEN;
    hold_req = 1'b1;
    repeat (n) send_sample(pick_sample(), 1'b0, '0);

    smp.valid <= 1'b0;
    while (filt_pending.size() != 0) @(negedge clk);
    repeat (2 * IDLE_GAP) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sfir_pkg.sv
rtl/core/sfir_if.sv
rtl/core/symmetric_fir_line_reflect_border_core.sv
tb/sv/tb.sv
